// ===== rtl/tetm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tetm_pkg
// Shared opcodes, error codes, word indexes and the saturating add of the transfer cost monitor.
// ----------------------------------------------------------------------------
package tetm_pkg;
    localparam logic [1:0] OP_LOG   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_ADDR  = 2'd1;
    localparam logic [1:0] ERR_CHAN  = 2'd2;
    localparam logic [1:0] ERR_BLEN  = 2'd3;

    localparam logic [6:0] ADDR_ENERGY = 7'd0;
    localparam logic [6:0] ADDR_TIME   = 7'd1;
    localparam int unsigned PARAM_BASE = 2;
    localparam int unsigned WPC        = 5;

    localparam logic [63:0] SAT64 = 64'hFFFF_FFFF_FFFF_FFFF;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? SAT64 : s[63:0];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/tetm_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tetm_mul
// Saturating 64x64 multiplier, 16 bits of b per cycle.
// ----------------------------------------------------------------------------
module tetm_mul (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_done,
    output logic [63:0]      o_p
);
    logic [63:0]  r_a, r_b;
    logic [127:0] r_acc;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic [79:0]  w_pp;
    logic [127:0] w_sum;

    assign w_pp  = r_a * r_b[15:0];
    assign w_sum = r_acc + ({48'd0, w_pp} << (r_cnt[1:0] * 16));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_acc <= w_sum;
                r_b   <= {16'd0, r_b[63:16]};
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd3) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_p = (|r_acc[127:64]) ? tetm_pkg::SAT64 : r_acc[63:0];
endmodule
`default_nettype wire

// ===== rtl/transfer_energy_time_monitor_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// transfer_energy_time_monitor_top
// Transfer time and energy totals with a per-channel cost parameter memory.
// ----------------------------------------------------------------------------
// Writes, undefined opcodes and bad-channel logs set the strobe at the
// accepting edge; reads strobe from S_RD, zero-burst-length logs from the
// first fetch, and other logs after 5 word fetches, a 32-step divider, six
// multiplies and the accumulate. busy is high from accepting a read or an
// in-range log until its strobe; one beat at a time. Reset is synchronous
// active low and clears counters and control. The parameter memory is cleared
// by a sweep of NUM_CHANNELS*5 words after reset, during which busy is high.
// ----------------------------------------------------------------------------
module transfer_energy_time_monitor_top #(
    parameter int NUM_CHANNELS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [3:0]  i_channel_index,
    input  wire logic [31:0] i_transfer_size,
    input  wire logic [6:0]  i_word_address,
    input  wire logic [31:0] i_write_value,
    output logic             o_strobe,
    output logic [63:0]      o_read_value,
    output logic [31:0]      o_transfer_time_ns,
    output logic [1:0]       o_error_code
);
    localparam int DEPTH = NUM_CHANNELS * tetm_pkg::WPC;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_FETCH = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_WAIT  = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;
    logic [AW-1:0] w_raddr;
    logic        w_we;
    logic [AW-1:0] w_waddr;
    logic [31:0] w_wdata;

    logic [3:0]  r_st;
    logic [AW:0] r_clr;
    logic [63:0] r_energy, r_time;
    logic [1:0]  r_op;
    logic [6:0]  r_addr;
    logic [AW-1:0] r_base;
    logic [31:0] r_size;
    logic [2:0]  r_fidx;
    logic [31:0] r_p [5];
    logic [31:0] r_q, r_rem;
    logic [5:0]  r_dcnt;
    logic [2:0]  r_step;
    logic [63:0] r_pb, r_tcost, r_ecost;
    logic        r_mstart;
    logic [63:0] r_ma, r_mb;
    logic        w_mdone;
    logic [63:0] w_mp;

    logic [7:0]  w_adr8;
    logic        w_addr_ok;
    logic [AW-1:0] w_pidx;
    logic [32:0] w_rsh, w_rsub;

    assign w_adr8    = {1'b0, i_word_address} - 8'(tetm_pkg::PARAM_BASE);
    assign w_addr_ok = i_word_address >= 7'(tetm_pkg::PARAM_BASE)
                       && 32'(w_adr8) < 32'(DEPTH);
    assign w_pidx    = w_adr8[AW-1:0];
    assign w_rsh     = {r_rem, r_q[31]};
    assign w_rsub    = w_rsh - {1'b0, r_p[0]};

    assign busy = (r_st != S_IDLE);

    tetm_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mstart),
        .i_a(r_ma), .i_b(r_mb), .o_done(w_mdone), .o_p(w_mp)
    );

    always_comb begin
        w_raddr = r_base + AW'(r_fidx);
        if (r_st == S_IDLE) begin
            w_raddr = (i_opcode == tetm_pkg::OP_LOG)
                ? AW'(32'(i_channel_index) * tetm_pkg::WPC) : w_pidx;
        end
        w_we    = 1'b0;
        w_waddr = r_clr[AW-1:0];
        w_wdata = '0;
        if (r_st == S_CLR) begin
            w_we = 1'b1;
        end else if (r_st == S_IDLE && start && i_opcode == tetm_pkg::OP_WRITE
                     && w_addr_ok) begin
            w_we    = 1'b1;
            w_waddr = w_pidx;
            w_wdata = i_write_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_CLR;
            r_clr    <= '0;
            r_energy <= '0;
            r_time   <= '0;
            o_strobe <= 1'b0;
            r_mstart <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            r_mstart <= 1'b0;
            unique case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == 32'(DEPTH - 1)) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        r_op   <= i_opcode;
                        r_addr <= i_word_address;
                        r_size <= i_transfer_size;
                        r_base <= AW'(32'(i_channel_index) * tetm_pkg::WPC);
                        r_fidx <= 3'd1;
                        o_read_value       <= '0;
                        o_transfer_time_ns <= '0;
                        o_error_code       <= tetm_pkg::ERR_OK;
                        case (i_opcode)
                            tetm_pkg::OP_LOG: begin
                                if (32'(i_channel_index) >= 32'(NUM_CHANNELS)) begin
                                    o_error_code <= tetm_pkg::ERR_CHAN;
                                    o_strobe     <= 1'b1;
                                end else begin
                                    r_st <= S_FETCH;
                                end
                            end
                            tetm_pkg::OP_READ: begin
                                r_st <= S_RD;
                            end
                            tetm_pkg::OP_WRITE: begin
                                r_energy <= '0;
                                r_time   <= '0;
                                if (i_word_address >= 7'(tetm_pkg::PARAM_BASE)
                                    && !w_addr_ok) begin
                                    o_error_code <= tetm_pkg::ERR_ADDR;
                                end
                                o_strobe <= 1'b1;
                            end
                            default: begin
                                o_strobe <= 1'b1;
                            end
                        endcase
                        if (i_opcode != tetm_pkg::OP_LOG
                            && i_opcode != tetm_pkg::OP_READ) r_st <= S_IDLE;
                    end
                end
                S_RD: begin
                    if (r_addr == tetm_pkg::ADDR_ENERGY) o_read_value <= r_energy;
                    else if (r_addr == tetm_pkg::ADDR_TIME) o_read_value <= r_time;
                    else if (32'(r_addr) - tetm_pkg::PARAM_BASE < 32'(DEPTH))
                        o_read_value <= {32'd0, r_rdata};
                    else o_error_code <= tetm_pkg::ERR_ADDR;
                    o_strobe <= 1'b1;
                    r_st     <= S_IDLE;
                end
                S_FETCH: begin
                    r_p[r_fidx - 3'd1] <= r_rdata;
                    r_fidx <= r_fidx + 3'd1;
                    if (r_fidx == 3'd1 && r_rdata == 32'd0) begin
                        o_error_code <= tetm_pkg::ERR_BLEN;
                        o_strobe     <= 1'b1;
                        r_st         <= S_IDLE;
                    end else if (r_fidx == 3'd5) begin
                        r_st   <= S_DIV;
                        r_q    <= r_size;
                        r_rem  <= '0;
                        r_dcnt <= '0;
                    end
                end
                S_DIV: begin
                    if (w_rsub[32]) begin
                        r_rem <= w_rsh[31:0];
                        r_q   <= {r_q[30:0], 1'b0};
                    end else begin
                        r_rem <= w_rsub[31:0];
                        r_q   <= {r_q[30:0], 1'b1};
                    end
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd31) begin
                        r_st     <= S_WAIT;
                        r_step   <= 3'd0;
                        r_mstart <= 1'b1;
                        r_ma     <= {32'd0, r_p[0]};
                        r_mb     <= {32'd0, r_p[2]};
                    end
                end
                S_WAIT: begin
                    if (w_mdone) begin
                        r_mstart <= 1'b1;
                        r_step   <= r_step + 3'd1;
                        case (r_step)
                            3'd0: begin
                                r_ma <= {32'd0, r_q};
                                r_mb <= tetm_pkg::sat_add({32'd0, r_p[1]}, w_mp);
                            end
                            3'd1: begin
                                r_tcost <= w_mp;
                                r_ma <= {32'd0, r_rem};
                                r_mb <= {32'd0, r_p[2]};
                            end
                            3'd2: begin
                                if (r_rem != 32'd0) r_tcost <= tetm_pkg::sat_add(r_tcost,
                                    tetm_pkg::sat_add({32'd0, r_p[1]}, w_mp));
                                r_ma <= {32'd0, r_p[0]};
                                r_mb <= {32'd0, r_p[4]};
                            end
                            3'd3: begin
                                r_ma <= {32'd0, r_q};
                                r_mb <= tetm_pkg::sat_add({32'd0, r_p[3]}, w_mp);
                            end
                            3'd4: begin
                                r_ecost <= w_mp;
                                r_ma <= {32'd0, r_rem};
                                r_mb <= {32'd0, r_p[4]};
                            end
                            default: begin
                                r_mstart <= 1'b0;
                                r_pb <= (r_rem != 32'd0) ? tetm_pkg::sat_add(r_ecost,
                                    tetm_pkg::sat_add({32'd0, r_p[3]}, w_mp)) : r_ecost;
                                r_st <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    r_time   <= tetm_pkg::sat_add(r_time, r_tcost);
                    r_energy <= tetm_pkg::sat_add(r_energy, r_pb);
                    o_transfer_time_ns <= (|r_tcost[63:32]) ? 32'hFFFF_FFFF
                                                            : r_tcost[31:0];
                    o_strobe <= 1'b1;
                    r_st     <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/tetm_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tetm_checker
// Port-level checks of the transfer cost monitor.
// ----------------------------------------------------------------------------
module tetm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_strobe,
    input wire logic [63:0] o_read_value,
    input wire logic [31:0] o_transfer_time_ns,
    input wire logic [1:0]  o_error_code
);
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_strobe) else $error("accept not tracked");
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy) else $error("strobe while busy");
    a_time_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_error_code != tetm_pkg::ERR_OK |-> o_transfer_time_ns == 32'd0)
        else $error("time on error");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_read_value == 64'd0 || o_transfer_time_ns == 32'd0)
        else $error("read and time both set");
endmodule

bind transfer_energy_time_monitor_top tetm_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_strobe(o_strobe), .o_read_value(o_read_value),
    .o_transfer_time_ns(o_transfer_time_ns), .o_error_code(o_error_code)
);
`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Testbench for transfer_energy_time_monitor_top. Drives log, read, write and
// undefined commands with random gaps, predicts every result from a local copy
// of the counters and parameter table, and checks each strobed result in order.
// ----------------------------------------------------------------------------
module tb;
    localparam int          NCH         = 16;
    localparam int          TBL_WORDS   = NCH * tetm_pkg::WPC;
    localparam logic [1:0]  OP_NONE     = 2'd3;
    localparam int          STALL_LIMIT = 5000;
    localparam logic [31:0] MAX32       = 32'hFFFF_FFFF;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_opcode;
    logic [3:0]  i_channel_index;
    logic [31:0] i_transfer_size;
    logic [6:0]  i_word_address;
    logic [31:0] i_write_value;
    logic        o_strobe;
    logic [63:0] o_read_value;
    logic [31:0] o_transfer_time_ns;
    logic [1:0]  o_error_code;

    typedef struct packed {
        logic [63:0] rd;
        logic [31:0] tm;
        logic [1:0]  err;
    } t_beat_result;

    t_beat_result pending_q[$];
    logic [63:0]  energy_acc;
    logic [63:0]  time_acc;
    logic [31:0]  cost_tbl [TBL_WORDS];
    int           fail_cnt = 0;
    int           stall_cnt = 0;
    int           beats_sent;

    transfer_energy_time_monitor_top #(.NUM_CHANNELS(NCH)) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_opcode           (i_opcode),
        .i_channel_index    (i_channel_index),
        .i_transfer_size    (i_transfer_size),
        .i_word_address     (i_word_address),
        .i_write_value      (i_write_value),
        .o_strobe           (o_strobe),
        .o_read_value       (o_read_value),
        .o_transfer_time_ns (o_transfer_time_ns),
        .o_error_code       (o_error_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? tetm_pkg::SAT64 : s[63:0];
    endfunction

    function automatic logic [63:0] mul_sat(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return (|p[127:64]) ? tetm_pkg::SAT64 : p[63:0];
    endfunction

    function automatic logic [63:0] transfer_cost(input logic [63:0] full,
                                                  input logic [63:0] resid,
                                                  input logic [63:0] blen,
                                                  input logic [31:0] setup,
                                                  input logic [31:0] per_beat);
        logic [63:0] total;
        total = mul_sat(full, add_sat({32'd0, setup}, mul_sat(blen, {32'd0, per_beat})));
        if (resid != 0)
            total = add_sat(total, add_sat({32'd0, setup}, mul_sat(resid, {32'd0, per_beat})));
        return total;
    endfunction

    function automatic t_beat_result predict_beat(input logic [1:0] op, input logic [3:0] ch,
                                                  input logic [31:0] size,
                                                  input logic [6:0] addr,
                                                  input logic [31:0] wval);
        t_beat_result r;
        logic [63:0]  blen;
        logic [63:0]  t;
        logic [63:0]  e;
        int           base;
        r = '0;
        case (op)
            tetm_pkg::OP_LOG: begin
                base = int'(ch) * tetm_pkg::WPC;
                if (int'(ch) >= NCH) begin
                    r.err = tetm_pkg::ERR_CHAN;
                end else if (cost_tbl[base] == 0) begin
                    r.err = tetm_pkg::ERR_BLEN;
                end else begin
                    blen = {32'd0, cost_tbl[base]};
                    t = transfer_cost({32'd0, size} / blen, {32'd0, size} % blen, blen,
                                      cost_tbl[base + 1], cost_tbl[base + 2]);
                    e = transfer_cost({32'd0, size} / blen, {32'd0, size} % blen, blen,
                                      cost_tbl[base + 3], cost_tbl[base + 4]);
                    time_acc   = add_sat(time_acc, t);
                    energy_acc = add_sat(energy_acc, e);
                    r.tm = (t > {32'd0, MAX32}) ? MAX32 : t[31:0];
                end
            end
            tetm_pkg::OP_READ: begin
                if (addr == tetm_pkg::ADDR_ENERGY)
                    r.rd = energy_acc;
                else if (addr == tetm_pkg::ADDR_TIME)
                    r.rd = time_acc;
                else if (int'(addr) - tetm_pkg::PARAM_BASE < TBL_WORDS)
                    r.rd = {32'd0, cost_tbl[int'(addr) - tetm_pkg::PARAM_BASE]};
                else
                    r.err = tetm_pkg::ERR_ADDR;
            end
            tetm_pkg::OP_WRITE: begin
                energy_acc = '0;
                time_acc   = '0;
                if (int'(addr) >= tetm_pkg::PARAM_BASE) begin
                    if (int'(addr) - tetm_pkg::PARAM_BASE < TBL_WORDS)
                        cost_tbl[int'(addr) - tetm_pkg::PARAM_BASE] = wval;
                    else
                        r.err = tetm_pkg::ERR_ADDR;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_beat(input logic [1:0] op, input logic [3:0] ch,
                             input logic [31:0] size, input logic [6:0] addr,
                             input logic [31:0] wval);
        int gap;
        i_opcode        <= op;
        i_channel_index <= ch;
        i_transfer_size <= size;
        i_word_address  <= addr;
        i_write_value   <= wval;
        start           <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_q.push_back(predict_beat(op, ch, size, addr, wval));
        beats_sent++;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 9) < 3)
            gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_word(input int ch, input int field, input logic [31:0] val);
        send_beat(tetm_pkg::OP_WRITE, 4'($urandom), $urandom,
                  7'(tetm_pkg::PARAM_BASE + ch * tetm_pkg::WPC + field), val);
    endtask

    task automatic read_word(input logic [6:0] addr);
        send_beat(tetm_pkg::OP_READ, 4'($urandom), $urandom, addr, $urandom);
    endtask

    task automatic log_xfer(input logic [3:0] ch, input logic [31:0] size);
        send_beat(tetm_pkg::OP_LOG, ch, size, 7'($urandom), $urandom);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 3);
            1, 2:    return $urandom_range(0, 40);
            3:       return $urandom_range(0, 5000);
            4:       return $urandom;
            default: return $urandom_range(0, 1) ? MAX32 : 32'h8000_0000;
        endcase
    endfunction

    task automatic test_reset_state();
        read_word(tetm_pkg::ADDR_ENERGY);
        read_word(tetm_pkg::ADDR_TIME);
        read_word(7'(tetm_pkg::PARAM_BASE));
        log_xfer(4'd0, 32'd10);
    endtask

    task automatic test_log_costs();
        write_word(0, 0, 32'd4);
        write_word(0, 1, 32'd10);
        write_word(0, 2, 32'd3);
        write_word(0, 3, 32'h0001_0000);
        write_word(0, 4, 32'h0000_8000);
        log_xfer(4'd0, 32'd0);
        log_xfer(4'd0, 32'd3);
        log_xfer(4'd0, 32'd4);
        log_xfer(4'd0, 32'd9);
        read_word(tetm_pkg::ADDR_ENERGY);
        read_word(tetm_pkg::ADDR_TIME);
    endtask

    task automatic test_saturation();
        for (int f = 0; f < tetm_pkg::WPC; f++)
            write_word(NCH - 1, f, MAX32);
        log_xfer(4'(NCH - 1), MAX32);
        log_xfer(4'(NCH - 1), 32'h7FFF_FFFF);
        read_word(tetm_pkg::ADDR_ENERGY);
        read_word(tetm_pkg::ADDR_TIME);
        read_word(7'(tetm_pkg::PARAM_BASE + TBL_WORDS - 1));
    endtask

    task automatic test_bad_access();
        read_word(7'(tetm_pkg::PARAM_BASE + TBL_WORDS));
        read_word(7'h7F);
        send_beat(tetm_pkg::OP_WRITE, 4'hF, MAX32, 7'h7F, MAX32);
        send_beat(tetm_pkg::OP_WRITE, 4'h0, 32'd0, tetm_pkg::ADDR_TIME, 32'h5A5A_5A5A);
        read_word(tetm_pkg::ADDR_TIME);
        log_xfer(4'd7, 32'd5);
        send_beat(OP_NONE, 4'hA, 32'h1234_5678, 7'd5, 32'h0BAD_F00D);
    endtask

    task automatic test_random_traffic(input int count);
        int ch;
        int target;
        target = beats_sent + count;
        while (beats_sent < target) begin
            if ($urandom_range(0, 9) < 4) begin
                ch = $urandom_range(0, NCH - 1);
                for (int f = 0; f < tetm_pkg::WPC; f++)
                    write_word(ch, f, (f == 0 && $urandom_range(0, 7) != 0)
                                      ? 32'($urandom_range(1, 16)) : pick_word());
            end
            repeat ($urandom_range(2, 8))
                log_xfer(4'($urandom_range(0, NCH - 1)), pick_word());
            read_word(tetm_pkg::ADDR_ENERGY);
            read_word(tetm_pkg::ADDR_TIME);
            case ($urandom_range(0, 5))
                0: read_word(7'($urandom_range(0, 127)));
                1: send_beat(tetm_pkg::OP_WRITE, 4'($urandom), $urandom,
                             7'($urandom_range(0, 127)), $urandom);
                2: send_beat(OP_NONE, 4'($urandom), $urandom, 7'($urandom), $urandom);
                3: read_word(7'($urandom_range(tetm_pkg::PARAM_BASE,
                                               tetm_pkg::PARAM_BASE + TBL_WORDS - 1)));
                default: ;
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        t_beat_result exp_r;
        if (i_rst_n && o_strobe) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result rd=%h tm=%h err=%0d", $time,
                         o_read_value, o_transfer_time_ns, o_error_code);
                fail_cnt++;
            end else begin
                exp_r = pending_q.pop_front();
                if (o_read_value !== exp_r.rd) begin
                    $display("%0t: read_value expected %h actual %h", $time,
                             exp_r.rd, o_read_value);
                    fail_cnt++;
                end
                if (o_transfer_time_ns !== exp_r.tm) begin
                    $display("%0t: transfer_time_ns expected %h actual %h", $time,
                             exp_r.tm, o_transfer_time_ns);
                    fail_cnt++;
                end
                if (o_error_code !== exp_r.err) begin
                    $display("%0t: error_code expected %0d actual %0d", $time,
                             exp_r.err, o_error_code);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("transfer_energy_time_monitor_top regression: fail");
                $finish;
            end
        end
    end

    initial begin
        beats_sent      = 0;
        energy_acc      = '0;
        time_acc        = '0;
        for (int i = 0; i < TBL_WORDS; i++)
            cost_tbl[i] = '0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_opcode        = tetm_pkg::OP_LOG;
        i_channel_index = '0;
        i_transfer_size = '0;
        i_word_address  = '0;
        i_write_value   = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_log_costs();
        test_saturation();
        test_bad_access();
        test_random_traffic(1020);
        start <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (fail_cnt == 0 && pending_q.size() == 0) begin
            $display("transfer_energy_time_monitor_top regression: pass");
        end else begin
            $display("transfer_energy_time_monitor_top regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
